FILE: sv/tbmt_pkg.sv
// Shared types and constants for the type bucket membership table.
// Holds payload widths, request and status codes, and the controller/datapath
// command and status bundles. No dependencies.
`default_nettype none

package tbmt_pkg;

   localparam int unsigned LIST_DEPTH_DEF = 256;
   localparam int unsigned TYPE_COUNT_DEF = 65;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned HANDLE_W = 32;
   localparam int unsigned TYPE_W   = 8;
   localparam int unsigned ENTRY_W  = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 9;

   typedef enum logic [KIND_W-1:0] {
      KIND_ADD    = 3'd0,
      KIND_REMOVE = 3'd1,
      KIND_TEST   = 3'd2,
      KIND_BUCKET = 3'd3,
      KIND_READ   = 3'd4
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_BAD_TYPE = 3'd1,
      ST_FULL     = 3'd2,
      ST_DUP      = 3'd3,
      ST_MISSING  = 3'd4
   } status_type;

   typedef struct packed {
      logic       load;
      logic       off_rd_lo;
      logic       off_rd_hi;
      logic       cap_hi;
      logic       scan;
      logic       shup_init;
      logic       shdn_init;
      logic       shup;
      logic       shdn;
      logic       commit;
      logic       ofs_init;
      logic       ofs;
      logic       list_rd_ent;
      logic       res_status;
      status_type code;
      logic       res_member;
      logic       res_bucket;
      logic       res_entry;
   } cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     type_ok;
      logic     full;
      logic     entry_ok;
      logic     scan_hit;
      logic     scan_end;
      logic     shup_done;
      logic     shdn_done;
      logic     ofs_done;
   } stat_type;

endpackage

`default_nettype wire

FILE: sv/tbmt_if.sv
// Request and response channel interfaces for the type bucket membership table.
// Depends on tbmt_pkg for payload widths.
`default_nettype none

interface tbmt_req_if import tbmt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [HANDLE_W-1:0] object_handle;
   logic [TYPE_W-1:0]   type_index;
   logic [ENTRY_W-1:0]  entry_index;

   modport source (output valid, output kind, output object_handle,
                   output type_index, output entry_index, input ready);
   modport sink   (input valid, input kind, input object_handle,
                   input type_index, input entry_index, output ready);
endinterface

interface tbmt_rsp_if import tbmt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                is_member;
   logic [COUNT_W-1:0]  bucket_start;
   logic [COUNT_W-1:0]  bucket_count;
   logic [HANDLE_W-1:0] entry_value;

   modport source (output valid, output status, output is_member, output bucket_start,
                   output bucket_count, output entry_value, input ready);
   modport sink   (input valid, input status, input is_member, input bucket_start,
                   input bucket_count, input entry_value, output ready);
endinterface

`default_nettype wire

FILE: sv/type_bucket_membership_table_core.sv
// Type bucket membership table, top level.
// Request channel req_bus: kind (add, remove, test, bucket query, read entry),
// object_handle, type_index, entry_index. Response channel rsp_bus: status,
// is_member, bucket_start, bucket_count, entry_value; one beat per request.
// One request is in flight at a time: req_bus.ready is high only while idle.
// Test and add/remove scan the bucket one entry per cycle from the
// single list memory read port; add/remove then move every later entry one
// place per cycle through the same port, and sweep the offsets after the
// bucket one per cycle. The block returns to idle after each response beat
// before the next request is taken.
// Reset clears the used count and all offset valid bits at once; no clearing
// pass is needed and the block takes a request in the first cycle after reset.
// The result stays on rsp_bus while rsp_bus.ready is low; the next request
// is taken once that beat completes.
// Depends on tbmt_pkg, tbmt_if, tbmt_ctrl and tbmt_dpath.
`default_nettype none

module type_bucket_membership_table_core import tbmt_pkg::*; #(
   parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
   parameter int unsigned TYPE_COUNT = TYPE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   tbmt_req_if.sink    req_bus,
   tbmt_rsp_if.source  rsp_bus
);

   cmd_type  cmd;
   stat_type stat;

   tbmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tbmt_dpath #(
      .LIST_DEPTH (LIST_DEPTH),
      .TYPE_COUNT (TYPE_COUNT)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_bus.kind),
      .req_object_handle (req_bus.object_handle),
      .req_type_index    (req_bus.type_index),
      .req_entry_index   (req_bus.entry_index),
      .rsp_status        (rsp_bus.status),
      .rsp_is_member     (rsp_bus.is_member),
      .rsp_bucket_start  (rsp_bus.bucket_start),
      .rsp_bucket_count  (rsp_bus.bucket_count),
      .rsp_entry_value   (rsp_bus.entry_value)
   );

endmodule

`default_nettype wire

FILE: sv/tbmt_ctrl.sv
// Controller state machine for the type bucket membership table.
// Sequences offset reads, bucket scan, list shifts and offset sweep; uses tbmt_pkg.
`default_nettype none

module tbmt_ctrl import tbmt_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_DECODE = 10'b0000000010,
      S_LO     = 10'b0000000100,
      S_HI     = 10'b0000001000,
      S_SCAN   = 10'b0000010000,
      S_SHUP   = 10'b0000100000,
      S_SHDN   = 10'b0001000000,
      S_OFS    = 10'b0010000000,
      S_ENT    = 10'b0100000000,
      S_RESP   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (stat.kind) inside
               KIND_ADD, KIND_REMOVE, KIND_TEST, KIND_BUCKET: begin
                  if (!stat.type_ok) begin
                     cmd.res_status = 1'b1;
                     cmd.code       = ST_BAD_TYPE;
                     state_in       = S_RESP;
                  end else if (stat.kind == KIND_ADD && stat.full) begin
                     cmd.res_status = 1'b1;
                     cmd.code       = ST_FULL;
                     state_in       = S_RESP;
                  end else begin
                     cmd.off_rd_lo = 1'b1;
                     state_in      = S_LO;
                  end
               end
               KIND_READ: begin
                  if (!stat.entry_ok) begin
                     cmd.res_status = 1'b1;
                     cmd.code       = ST_MISSING;
                     state_in       = S_RESP;
                  end else begin
                     cmd.list_rd_ent = 1'b1;
                     state_in        = S_ENT;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_LO: begin
            cmd.off_rd_hi = 1'b1;
            state_in      = S_HI;
         end
         S_HI: begin
            if (stat.kind == KIND_BUCKET) begin
               cmd.res_bucket = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.cap_hi = 1'b1;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_hit) begin
               unique case (stat.kind)
                  KIND_ADD: begin
                     cmd.res_status = 1'b1;
                     cmd.code       = ST_DUP;
                     state_in       = S_RESP;
                  end
                  KIND_REMOVE: begin
                     cmd.shdn_init = 1'b1;
                     state_in      = S_SHDN;
                  end
                  KIND_TEST: begin
                     cmd.res_member = 1'b1;
                     state_in       = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end else if (stat.scan_end) begin
               unique case (stat.kind)
                  KIND_ADD: begin
                     cmd.shup_init = 1'b1;
                     state_in      = S_SHUP;
                  end
                  KIND_REMOVE: begin
                     cmd.res_status = 1'b1;
                     cmd.code       = ST_MISSING;
                     state_in       = S_RESP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_SHUP: begin
            if (stat.shup_done) begin
               cmd.commit   = 1'b1;
               cmd.ofs_init = 1'b1;
               state_in     = S_OFS;
            end else begin
               cmd.shup = 1'b1;
            end
         end
         S_SHDN: begin
            if (stat.shdn_done) begin
               cmd.commit   = 1'b1;
               cmd.ofs_init = 1'b1;
               state_in     = S_OFS;
            end else begin
               cmd.shdn = 1'b1;
            end
         end
         S_OFS: begin
            if (stat.ofs_done) begin
               state_in = S_RESP;
            end else begin
               cmd.ofs = 1'b1;
            end
         end
         S_ENT: begin
            cmd.res_entry = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: sv/tbmt_dpath.sv
// Datapath for the type bucket membership table: handle list memory, bucket
// offset memory with valid bits, scan/shift/sweep pointers and result registers.
// Uses tbmt_pkg; driven by tbmt_ctrl.
`default_nettype none

module tbmt_dpath import tbmt_pkg::*; #(
   parameter int unsigned LIST_DEPTH = LIST_DEPTH_DEF,
   parameter int unsigned TYPE_COUNT = TYPE_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [HANDLE_W-1:0] req_object_handle,
   input  logic [TYPE_W-1:0]   req_type_index,
   input  logic [ENTRY_W-1:0]  req_entry_index,
   output logic [STATUS_W-1:0] rsp_status,
   output logic                rsp_is_member,
   output logic [COUNT_W-1:0]  rsp_bucket_start,
   output logic [COUNT_W-1:0]  rsp_bucket_count,
   output logic [HANDLE_W-1:0] rsp_entry_value
);

   localparam int unsigned LA  = $clog2(LIST_DEPTH);
   localparam int unsigned LW  = $clog2(LIST_DEPTH + 1);
   localparam int unsigned TA  = $clog2(TYPE_COUNT + 1);
   localparam int unsigned TW1 = $clog2(TYPE_COUNT + 2);
   localparam int unsigned EW  = (LW > ENTRY_W) ? LW : ENTRY_W;

   kind_type            kind_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [TYPE_W-1:0]   type_ff;
   logic [ENTRY_W-1:0]  entry_ff;

   logic [LW-1:0]  lo_ff, hi_ff, ptr_ff, pos_ff, used_ff;
   logic [LA-1:0]  wdst_ff;
   logic           pend_ff;
   logic [TW1-1:0] optr_ff;
   logic [TA-1:0]  owdst_ff;
   logic           opend_ff;

   status_type          status_ff;
   logic                member_ff;
   logic [COUNT_W-1:0]  bstart_ff, bcount_ff;
   logic [HANDLE_W-1:0] value_ff;

   logic [HANDLE_W-1:0] list_mem [LIST_DEPTH];
   logic [HANDLE_W-1:0] list_rdata_ff;
   logic [LA-1:0]       list_raddr, list_waddr;
   logic [HANDLE_W-1:0] list_wdata;
   logic                list_we;

   logic [LW-1:0] off_mem [TYPE_COUNT + 1];
   logic          off_vld_ff [TYPE_COUNT + 1];
   logic [LW-1:0] off_rdata_ff;
   logic          off_rvld_ff;
   logic [TA-1:0] off_raddr;
   logic [TA-1:0] type_addr;

   logic [LW-1:0] off_val, off_adj, ins_pos, ptr_inc, ptr_dec;
   logic          type_ok, scan_hit, scan_end, is_add;

   assign is_add    = (kind_ff == KIND_ADD);
   assign off_val   = off_rvld_ff ? off_rdata_ff : '0;
   assign type_addr = TA'(type_ff);
   assign type_ok   = {1'b0, type_ff} < COUNT_W'(TYPE_COUNT);
   assign ptr_inc   = ptr_ff + LW'(1);
   assign ptr_dec   = ptr_ff - LW'(1);
   assign ins_pos   = (hi_ff == lo_ff) ? lo_ff : hi_ff - LW'(1);
   assign scan_hit  = pend_ff && (list_rdata_ff == handle_ff);
   assign scan_end  = !scan_hit && (ptr_ff >= hi_ff);

   always_comb begin
      if (is_add) begin
         off_adj = off_val + LW'(1);
      end else if (off_val != '0) begin
         off_adj = off_val - LW'(1);
      end else begin
         off_adj = '0;
      end
   end

   always_comb begin
      stat.kind      = kind_ff;
      stat.type_ok   = type_ok;
      stat.full      = used_ff >= LW'(LIST_DEPTH);
      stat.entry_ok  = EW'(entry_ff) < EW'(used_ff);
      stat.scan_hit  = scan_hit;
      stat.scan_end  = scan_end;
      stat.shup_done = !pend_ff && !(ptr_ff > pos_ff);
      stat.shdn_done = !pend_ff && !(ptr_inc < used_ff);
      stat.ofs_done  = !opend_ff && (optr_ff > TW1'(TYPE_COUNT));
   end

   // list memory ports
   always_comb begin
      if (cmd.list_rd_ent) begin
         list_raddr = LA'(entry_ff);
      end else if (cmd.shup) begin
         list_raddr = LA'(ptr_dec);
      end else if (cmd.shdn) begin
         list_raddr = LA'(ptr_inc);
      end else begin
         list_raddr = LA'(ptr_ff);
      end
      list_we    = 1'b0;
      list_waddr = wdst_ff;
      list_wdata = list_rdata_ff;
      if ((cmd.shup || cmd.shdn) && pend_ff) begin
         list_we = 1'b1;
      end else if (cmd.commit && is_add) begin
         list_we    = 1'b1;
         list_waddr = LA'(pos_ff);
         list_wdata = handle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[list_waddr] <= list_wdata;
      end
      list_rdata_ff <= list_mem[list_raddr];
   end

   // offset memory ports
   always_comb begin
      if (cmd.off_rd_lo) begin
         off_raddr = type_addr;
      end else if (cmd.off_rd_hi) begin
         off_raddr = type_addr + TA'(1);
      end else begin
         off_raddr = TA'(optr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ofs && opend_ff) begin
         off_mem[owdst_ff] <= off_adj;
      end
      off_rdata_ff <= off_mem[off_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= int'(TYPE_COUNT); i++) begin
            off_vld_ff[i] <= 1'b0;
         end
         off_rvld_ff <= 1'b0;
         used_ff     <= '0;
         pend_ff     <= 1'b0;
         opend_ff    <= 1'b0;
      end else begin
         if (cmd.ofs && opend_ff) begin
            off_vld_ff[owdst_ff] <= 1'b1;
         end
         off_rvld_ff <= off_vld_ff[off_raddr];
         if (cmd.commit) begin
            used_ff <= is_add ? used_ff + LW'(1) : used_ff - LW'(1);
         end
         if (cmd.cap_hi || cmd.shup_init || cmd.shdn_init) begin
            pend_ff <= 1'b0;
         end else if (cmd.scan) begin
            pend_ff <= 1'b1;
         end else if (cmd.shup) begin
            pend_ff <= ptr_ff > pos_ff;
         end else if (cmd.shdn) begin
            pend_ff <= ptr_inc < used_ff;
         end
         if (cmd.ofs_init) begin
            opend_ff <= 1'b0;
         end else if (cmd.ofs) begin
            opend_ff <= optr_ff <= TW1'(TYPE_COUNT);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= kind_type'(req_kind);
         handle_ff <= req_object_handle;
         type_ff   <= req_type_index;
         entry_ff  <= req_entry_index;
         status_ff <= ST_OK;
         member_ff <= 1'b0;
         bstart_ff <= '0;
         bcount_ff <= '0;
         value_ff  <= '0;
      end
      if (cmd.off_rd_hi) begin
         lo_ff <= off_val;
      end
      if (cmd.cap_hi) begin
         hi_ff  <= off_val;
         ptr_ff <= lo_ff;
      end
      if (cmd.scan) begin
         ptr_ff <= ptr_inc;
      end
      if (cmd.shup_init) begin
         pos_ff <= ins_pos;
         ptr_ff <= used_ff;
      end
      if (cmd.shdn_init) begin
         pos_ff <= ptr_dec;
         ptr_ff <= ptr_dec;
      end
      if (cmd.shup && (ptr_ff > pos_ff)) begin
         wdst_ff <= LA'(ptr_ff);
         ptr_ff  <= ptr_dec;
      end
      if (cmd.shdn && (ptr_inc < used_ff)) begin
         wdst_ff <= LA'(ptr_ff);
         ptr_ff  <= ptr_inc;
      end
      if (cmd.ofs_init) begin
         optr_ff <= TW1'(type_ff) + TW1'(1);
      end
      if (cmd.ofs && (optr_ff <= TW1'(TYPE_COUNT))) begin
         owdst_ff <= TA'(optr_ff);
         optr_ff  <= optr_ff + TW1'(1);
      end
      if (cmd.res_status) begin
         status_ff <= cmd.code;
      end
      if (cmd.res_member) begin
         member_ff <= 1'b1;
      end
      if (cmd.res_bucket) begin
         bstart_ff <= COUNT_W'(lo_ff);
         bcount_ff <= (off_val >= lo_ff) ? COUNT_W'(off_val - lo_ff) : '0;
      end
      if (cmd.res_entry) begin
         value_ff <= list_rdata_ff;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_is_member    = member_ff;
   assign rsp_bucket_start = bstart_ff;
   assign rsp_bucket_count = bcount_ff;
   assign rsp_entry_value  = value_ff;

   a_add_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && is_add) |=> (used_ff == $past(used_ff) + LW'(1)))
      else $error("insert did not advance the used count");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> (ptr_ff < hi_ff))
      else $error("scan read past bucket end");

   a_shift_apart: assert property (@(posedge clock) disable iff (reset)
      (list_we && (cmd.shup || cmd.shdn)) |-> (list_waddr != list_raddr))
      else $error("shift writes the entry it reads");

   a_ofs_range: assert property (@(posedge clock) disable iff (reset)
      opend_ff |-> (owdst_ff <= TA'(TYPE_COUNT)))
      else $error("offset sweep beyond table");

endmodule

`default_nettype wire
